@@ sv/dsha_pkg.sv @@
// ----------------------------------------------------------------------------
// dsha_pkg: shared types and constants for the double SHA-256 nonce search
// SHA-256 round constants, initial value, message padding words, sigma
// functions and the pipeline stage record.
// ----------------------------------------------------------------------------
package dsha_pkg;

   typedef logic [31:0] word_type;

   // Pipeline stage record: working variables (a..h at 0..7) and the
   // sixteen-word schedule window, current word at index 0.
   typedef struct packed {
      logic [31:0]    nonce;
      word_type [7:0] st;
      word_type [15:0] w;
   } stage_type;

   typedef enum logic {
      REG_BATCH_SIZE = 1'b0,
      REG_ZERO_BITS  = 1'b1
   } reg_index_type;

   localparam int       BATCH_W      = 17;
   localparam int       ZBITS_W      = 6;
   localparam longint   MAX_BATCH    = 65536;
   localparam int       BATCH_RESET  = 65536;
   localparam int       ZBITS_RESET  = 16;
   localparam word_type PAD_WORD     = 32'h8000_0000;
   localparam word_type LEN_FIRST    = 32'd640;
   localparam word_type LEN_SECOND   = 32'd256;

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam word_type INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type swap32(input word_type x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

   function automatic word_type ssig0(input word_type x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type ssig1(input word_type x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type bsig0(input word_type x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type bsig1(input word_type x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage

@@ sv/dsha_if.sv @@
// ----------------------------------------------------------------------------
// dsha_if: channel interfaces for the nonce search
// Job request, result and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dsha_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [63:0] midstate_w0w1;
   logic [63:0] midstate_w2w3;
   logic [63:0] midstate_w4w5;
   logic [63:0] midstate_w6w7;
   logic [63:0] tail_w0w1;
   logic [31:0] tail_w2;
   logic [31:0] start_nonce;

   modport source (output valid, mode, midstate_w0w1, midstate_w2w3, midstate_w4w5,
                   midstate_w6w7, tail_w0w1, tail_w2, start_nonce, input ready);
   modport sink (input valid, mode, midstate_w0w1, midstate_w2w3, midstate_w4w5,
                 midstate_w6w7, tail_w0w1, tail_w2, start_nonce, output ready);
endinterface

interface dsha_rsp_if;
   logic        valid;
   logic        ready;
   logic        share_found;
   logic [31:0] nonce_out;
   logic [16:0] hashes_done;
   logic [63:0] digest_h0h1;
   logic [63:0] digest_h2h3;
   logic [63:0] digest_h4h5;
   logic [63:0] digest_h6h7;

   modport source (output valid, share_found, nonce_out, hashes_done, digest_h0h1,
                   digest_h2h3, digest_h4h5, digest_h6h7, input ready);
   modport sink (input valid, share_found, nonce_out, hashes_done, digest_h0h1,
                 digest_h2h3, digest_h4h5, digest_h6h7, output ready);
endinterface

interface dsha_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [16:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ sv/dsha_round.sv @@
// ----------------------------------------------------------------------------
// dsha_round: one SHA-256 round stage
// Applies one round to the working variables and advances the schedule window.
// ----------------------------------------------------------------------------
module dsha_round
   import dsha_pkg::*;
#(
   parameter int ROUND = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  stage_type in_data,
   output logic      out_valid,
   output stage_type out_data
);

   word_type  t1;
   word_type  t2;
   word_type  chs;
   word_type  maj;
   word_type  w_new;
   stage_type data_in;
   logic      valid_ff;
   stage_type data_ff;

   always_comb begin
      chs   = (in_data.st[4] & in_data.st[5]) ^ (~in_data.st[4] & in_data.st[6]);
      maj   = (in_data.st[0] & in_data.st[1]) ^ (in_data.st[0] & in_data.st[2])
            ^ (in_data.st[1] & in_data.st[2]);
      t1    = in_data.st[7] + bsig1(in_data.st[4]) + chs + ROUND_K[ROUND] + in_data.w[0];
      t2    = bsig0(in_data.st[0]) + maj;
      w_new = in_data.w[0] + ssig0(in_data.w[1]) + in_data.w[9] + ssig1(in_data.w[14]);

      data_in       = in_data;
      data_in.st[7] = in_data.st[6];
      data_in.st[6] = in_data.st[5];
      data_in.st[5] = in_data.st[4];
      data_in.st[4] = in_data.st[3] + t1;
      data_in.st[3] = in_data.st[2];
      data_in.st[2] = in_data.st[1];
      data_in.st[1] = in_data.st[0];
      data_in.st[0] = t1 + t2;
      for (int i = 0; i < 15; i++) begin
         data_in.w[i] = in_data.w[i + 1];
      end
      data_in.w[15] = w_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ sv/dsha_compress.sv @@
// ----------------------------------------------------------------------------
// dsha_compress: 64-stage SHA-256 compression pipeline
// One round per stage; feed-forward add is left to the caller.
// ----------------------------------------------------------------------------
module dsha_compress
   import dsha_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  stage_type in_data,
   output logic      out_valid,
   output stage_type out_data
);

   logic      chain_valid [65];
   stage_type chain_data  [65];

   assign chain_valid[0] = in_valid;
   assign chain_data[0]  = in_data;

   for (genvar g = 0; g < 64; g++) begin : g_round
      dsha_round #(.ROUND(g)) u_round (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (chain_valid[g]),
         .in_data  (chain_data[g]),
         .out_valid(chain_valid[g + 1]),
         .out_data (chain_data[g + 1])
      );
   end

   assign out_valid = chain_valid[64];
   assign out_data  = chain_data[64];

endmodule

@@ sv/dsha_pipe.sv @@
// ----------------------------------------------------------------------------
// dsha_pipe: double SHA-256 hash pipeline
// First block from midstate, second from the initial value, final add stage.
// ----------------------------------------------------------------------------
module dsha_pipe
   import dsha_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  logic [31:0]    in_nonce,
   input  word_type [7:0] mid,
   input  word_type [2:0] tail,
   output logic           out_valid,
   output logic [31:0]    out_nonce,
   output word_type [7:0] out_dig
);

   stage_type      first_in;
   logic           first_valid;
   stage_type      first_out;
   stage_type      second_in;
   logic           second_valid;
   stage_type      second_out;
   word_type [7:0] dig_in;
   logic           valid_ff;
   logic [31:0]    nonce_ff;
   word_type [7:0] dig_ff;

   // Block one: tail words, byte-swapped nonce, padding and 640-bit length.
   always_comb begin
      first_in       = '0;
      first_in.nonce = in_nonce;
      first_in.st    = mid;
      first_in.w[0]  = tail[0];
      first_in.w[1]  = tail[1];
      first_in.w[2]  = tail[2];
      first_in.w[3]  = swap32(in_nonce);
      first_in.w[4]  = PAD_WORD;
      first_in.w[15] = LEN_FIRST;
   end

   dsha_compress u_first (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (in_valid),
      .in_data  (first_in),
      .out_valid(first_valid),
      .out_data (first_out)
   );

   // Block two: first digest, padding and 256-bit length, from the initial value.
   always_comb begin
      second_in       = '0;
      second_in.nonce = first_out.nonce;
      for (int i = 0; i < 8; i++) begin
         second_in.w[i]  = first_out.st[i] + mid[i];
         second_in.st[i] = INIT_H[i];
      end
      second_in.w[8]  = PAD_WORD;
      second_in.w[15] = LEN_SECOND;
   end

   dsha_compress u_second (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (first_valid),
      .in_data  (second_in),
      .out_valid(second_valid),
      .out_data (second_out)
   );

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         dig_in[i] = second_out.st[i] + INIT_H[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= second_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nonce_ff <= second_out.nonce;
         dig_ff   <= dig_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_nonce = nonce_ff;
   assign out_dig   = dig_ff;

endmodule

@@ sv/double_sha256_nonce_search.sv @@
// ----------------------------------------------------------------------------
// double_sha256_nonce_search: midstate-based double SHA-256 nonce search
// Job control, nonce issue, result collection and register file.
// ----------------------------------------------------------------------------
// A job beat carries a midstate, three tail words and a start nonce. The hash
// pipeline is 129 register stages deep (64 rounds per compression, one round
// a stage, plus a final add) and takes a new nonce every cycle while it is
// not frozen behind a result beat that has not been taken. The
// block works on one job at a time: a new job beat is taken once the previous
// job has finished and every nonce still in the pipeline has drained out.
// Nonces issued past the first share are hashed but dropped. The result beat
// sits in an output register; while it waits, the pipeline freezes only if
// the next job's result is ready to be written over it.
module double_sha256_nonce_search
   import dsha_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   dsha_req_if.sink   req_ch,
   dsha_rsp_if.source rsp_ch,
   dsha_csr_if.sink   csr_ch
);

   // registers
   logic [BATCH_W-1:0] batch_ff;
   logic [ZBITS_W-1:0] zbits_ff;
   logic               active_ff;
   logic [BATCH_W-1:0] limit_ff;
   logic [BATCH_W-1:0] issued_ff;
   logic [BATCH_W-1:0] done_ff;
   logic [31:0]        nonce_ff;
   logic [7:0]         inflight_ff;
   word_type [7:0]     mid_ff;
   word_type [2:0]     tail_ff;

   logic               rsp_valid_ff;
   logic               found_ff;
   logic [31:0]        nout_ff;
   logic [BATCH_W-1:0] hdone_ff;
   word_type [7:0]     dig_ff;

   // next values and control
   logic [BATCH_W-1:0] limit_in;
   logic [BATCH_W-1:0] done_in;
   logic [7:0]         inflight_in;
   logic               req_fire;
   logic               adv;
   logic               issue;
   logic               retire;
   logic               pipe_valid;
   logic [31:0]        pipe_nonce;
   word_type [7:0]     pipe_dig;
   word_type           mask;
   logic               hit;
   logic               finish;
   logic               finish_fire;

   // Registers: write any time, always ready.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_ff <= BATCH_W'(BATCH_RESET);
         zbits_ff <= ZBITS_W'(ZBITS_RESET);
      end else if (csr_ch.valid) begin
         case (reg_index_type'(csr_ch.index))
            REG_BATCH_SIZE: batch_ff <= csr_ch.data[BATCH_W-1:0];
            REG_ZERO_BITS:  zbits_ff <= csr_ch.data[ZBITS_W-1:0];
            default: ;
         endcase
      end
   end

   // Take a job only with the pipeline empty and no job running.
   assign req_ch.ready = !active_ff && (inflight_ff == 8'd0);
   assign req_fire     = req_ch.valid && req_ch.ready;

   // Clamp the batch: zero means one, cap at MAX_BATCH, verify is one.
   always_comb begin
      if (req_ch.mode || (batch_ff == '0)) begin
         limit_in = BATCH_W'(1);
      end else if ({16'd0, batch_ff} > 33'(MAX_BATCH)) begin
         limit_in = BATCH_W'(MAX_BATCH);
      end else begin
         limit_in = batch_ff;
      end
   end

   // Zero-bits test on final H0.
   always_comb begin
      mask = ~(32'hffff_ffff >> zbits_ff);
      if (zbits_ff > ZBITS_W'(32)) begin
         hit = 1'b0;
      end else begin
         hit = (pipe_dig[0] & mask) == 32'd0;
      end
   end

   assign done_in = done_ff + BATCH_W'(1);
   assign finish  = pipe_valid && active_ff && (hit || (done_in == limit_ff));

   // Freeze the pipeline only when a finishing result has nowhere to go.
   assign adv         = !(finish && rsp_valid_ff && !rsp_ch.ready);
   assign issue       = active_ff && (issued_ff != limit_ff) && adv;
   assign retire      = pipe_valid && adv;
   assign finish_fire = finish && adv;
   assign inflight_in = inflight_ff + 8'(issue) - 8'(retire);

   dsha_pipe u_pipe (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (active_ff && (issued_ff != limit_ff)),
      .in_nonce (nonce_ff),
      .mid      (mid_ff),
      .tail     (tail_ff),
      .out_valid(pipe_valid),
      .out_nonce(pipe_nonce),
      .out_dig  (pipe_dig)
   );

   // Job control: hold job words, advance nonce, count beats in flight.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         inflight_ff <= 8'd0;
      end else begin
         inflight_ff <= inflight_in;
         if (req_fire) begin
            active_ff <= 1'b1;
         end else if (finish_fire) begin
            active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         limit_ff  <= limit_in;
         issued_ff <= '0;
         done_ff   <= '0;
         nonce_ff  <= req_ch.start_nonce;
         mid_ff    <= {req_ch.midstate_w6w7[31:0], req_ch.midstate_w6w7[63:32],
                       req_ch.midstate_w4w5[31:0], req_ch.midstate_w4w5[63:32],
                       req_ch.midstate_w2w3[31:0], req_ch.midstate_w2w3[63:32],
                       req_ch.midstate_w0w1[31:0], req_ch.midstate_w0w1[63:32]};
         tail_ff   <= {req_ch.tail_w2, req_ch.tail_w0w1[31:0], req_ch.tail_w0w1[63:32]};
      end else begin
         if (issue) begin
            issued_ff <= issued_ff + BATCH_W'(1);
            nonce_ff  <= nonce_ff + 32'd1;
         end
         if (retire && active_ff) begin
            done_ff <= done_in;
         end
      end
   end

   // Result register: load on finish, drop when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_fire) begin
         found_ff <= hit;
         nout_ff  <= hit ? pipe_nonce : pipe_nonce + 32'd1;
         hdone_ff <= done_in;
         dig_ff   <= pipe_dig;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.share_found = found_ff;
   assign rsp_ch.nonce_out   = nout_ff;
   assign rsp_ch.hashes_done = hdone_ff;
   assign rsp_ch.digest_h0h1 = {dig_ff[0], dig_ff[1]};
   assign rsp_ch.digest_h2h3 = {dig_ff[2], dig_ff[3]};
   assign rsp_ch.digest_h4h5 = {dig_ff[4], dig_ff[5]};
   assign rsp_ch.digest_h6h7 = {dig_ff[6], dig_ff[7]};

endmodule
